// ===== design/link_health_led_qualifier_unit_assert.svh =====
// Assertion macros for the link health LED qualifier.
// Depends on a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef LINK_HEALTH_LED_QUALIFIER_UNIT_ASSERT_SVH
`define LINK_HEALTH_LED_QUALIFIER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LHQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LHQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lhq_pkg.sv =====
// Shared types and constants for the link health LED qualifier.
// No dependencies.
package lhq_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int LAT_W = 16;
	localparam int COUNT_W = 8;
	localparam int PHASE_W = 17;

	typedef enum logic [1:0] {
		ZONE_GOOD = 2'd0,
		ZONE_DEGRADED = 2'd1,
		ZONE_BAD = 2'd2
	} zone_t;

	typedef enum logic [1:0] {
		MODE_STEADY = 2'd0,
		MODE_SLOW = 2'd1,
		MODE_FAST = 2'd2
	} mode_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_PING = 1'b1
	} opcode_t;

	localparam logic [CFG_IDX_W-1:0] REG_GOOD_MAX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STREAK_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_ON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_OFF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_ON = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_OFF = 3'd6;

endpackage

// ===== design/lhq_item_if.sv =====
// Input channel of the link health LED qualifier: ticks and ping results.
// Depends on lhq_pkg.
interface lhq_item_if;
	import lhq_pkg::*;

	logic valid;
	logic ready;
	logic opcode;
	logic ping_ok;
	logic [LAT_W-1:0] latency_ms;

	modport source (output valid, opcode, ping_ok, latency_ms, input ready);
	modport sink (input valid, opcode, ping_ok, latency_ms, output ready);
endinterface

// ===== design/lhq_result_if.sv =====
// Result channel of the link health LED qualifier: LED level and streak status.
// Depends on lhq_pkg.
interface lhq_result_if;
	import lhq_pkg::*;

	logic valid;
	logic ready;
	logic led_on;
	logic [1:0] led_mode;
	logic [1:0] zone;
	logic [COUNT_W-1:0] run_length;

	modport source (output valid, led_on, led_mode, zone, run_length, input ready);
	modport sink (input valid, led_on, led_mode, zone, run_length, output ready);
endinterface

// ===== design/lhq_cfg_if.sv =====
// Configuration write channel of the link health LED qualifier.
// Depends on lhq_pkg.
interface lhq_cfg_if;
	import lhq_pkg::*;

	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/link_health_led_qualifier_unit.sv =====
// Link health LED qualifier: classes ping results into streaks and drives a blinking LED.
// Depends on lhq_pkg, lhq_item_if, lhq_result_if, lhq_cfg_if and the assertion macros.
//
// Each transfer on item_in is a one millisecond tick or a ping result, and each one yields
// exactly one transfer on result_out. An item is captured in an input register and is
// qualified once the result register is free or being drained, when the streak, mode and
// blink phase are updated and the result register is loaded; one item is taken every
// cycle as long as result_out is drained. Both registers can fill while result_out is
// stalled. Configuration writes are always taken in the cycle they are offered, and must
// only be made while no item is in flight.
module link_health_led_qualifier_unit #(
	parameter int STREAK_LIMIT = 255
) (
	input logic clk,
	input logic arst_n,
	lhq_item_if.sink item_in,
	lhq_result_if.source result_out,
	lhq_cfg_if.sink cfg
);
	import lhq_pkg::*;

	`include "link_health_led_qualifier_unit_assert.svh"

	localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(STREAK_LIMIT);

	logic [LAT_W-1:0] good_max_q;
	logic [LAT_W-1:0] degraded_max_q;
	logic [COUNT_W-1:0] threshold_q;
	logic [LAT_W-1:0] slow_on_q;
	logic [LAT_W-1:0] slow_off_q;
	logic [LAT_W-1:0] fast_on_q;
	logic [LAT_W-1:0] fast_off_q;

	logic valid_s1;
	opcode_t opcode_s1;
	logic ping_ok_s1;
	logic [LAT_W-1:0] latency_s1;

	zone_t zone_q;
	logic [COUNT_W-1:0] count_q;
	mode_t mode_q;
	logic [PHASE_W-1:0] phase_q;

	logic out_valid_q;
	logic led_q;
	mode_t led_mode_q;
	zone_t out_zone_q;
	logic [COUNT_W-1:0] run_length_q;

	logic advance;
	zone_t ping_zone;
	zone_t zone_d;
	logic [COUNT_W-1:0] count_d;
	mode_t mode_d;
	mode_t ping_mode;
	logic [PHASE_W-1:0] phase_d;
	logic [PHASE_W-1:0] phase_inc;
	logic [PHASE_W-1:0] period;
	logic [LAT_W-1:0] on_time;
	logic led_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_max_q <= 16'd60;
			degraded_max_q <= 16'd90;
			threshold_q <= 8'd3;
			slow_on_q <= 16'd500;
			slow_off_q <= 16'd500;
			fast_on_q <= 16'd100;
			fast_off_q <= 16'd100;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GOOD_MAX: good_max_q <= cfg.data;
				REG_DEGRADED_MAX: degraded_max_q <= cfg.data;
				REG_STREAK_THRESHOLD: threshold_q <= cfg.data[COUNT_W-1:0];
				REG_SLOW_ON: slow_on_q <= cfg.data;
				REG_SLOW_OFF: slow_off_q <= cfg.data;
				REG_FAST_ON: fast_on_q <= cfg.data;
				REG_FAST_OFF: fast_off_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			opcode_s1 <= opcode_t'(item_in.opcode);
			ping_ok_s1 <= item_in.ping_ok;
			latency_s1 <= item_in.latency_ms;
		end
	end

	always_comb begin
		if (!ping_ok_s1 || latency_s1 > degraded_max_q) begin
			ping_zone = ZONE_BAD;
		end else if (latency_s1 > good_max_q) begin
			ping_zone = ZONE_DEGRADED;
		end else begin
			ping_zone = ZONE_GOOD;
		end
	end

	assign period = (mode_q == MODE_FAST) ? PHASE_W'(fast_on_q) + PHASE_W'(fast_off_q)
		: PHASE_W'(slow_on_q) + PHASE_W'(slow_off_q);
	assign phase_inc = phase_q + PHASE_W'(1);

	always_comb begin
		zone_d = zone_q;
		count_d = count_q;
		mode_d = mode_q;
		phase_d = phase_q;
		ping_mode = MODE_STEADY;
		if (opcode_s1 == OP_PING) begin
			if (ping_zone == zone_q) begin
				count_d = (count_q < LIMIT) ? count_q + COUNT_W'(1) : count_q;
			end else begin
				zone_d = ping_zone;
				count_d = COUNT_W'(1);
			end
			if (count_d >= threshold_q) begin
				unique case (zone_d)
					ZONE_BAD: ping_mode = MODE_FAST;
					ZONE_DEGRADED: ping_mode = MODE_SLOW;
					default: ping_mode = MODE_STEADY;
				endcase
			end
			mode_d = ping_mode;
			if (ping_mode != mode_q) begin
				phase_d = '0;
			end
		end else if (mode_q != MODE_STEADY) begin
			phase_d = (phase_inc >= period) ? '0 : phase_inc;
		end
	end

	assign on_time = (mode_d == MODE_FAST) ? fast_on_q : slow_on_q;
	assign led_d = (mode_d == MODE_STEADY) || (phase_d < PHASE_W'(on_time));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_GOOD;
			count_q <= '0;
			mode_q <= MODE_STEADY;
			phase_q <= '0;
		end else if (advance) begin
			zone_q <= zone_d;
			count_q <= count_d;
			mode_q <= mode_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_q <= led_d;
			led_mode_q <= mode_d;
			out_zone_q <= zone_d;
			run_length_q <= count_d;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.led_on = led_q;
	assign result_out.led_mode = led_mode_q;
	assign result_out.zone = out_zone_q;
	assign result_out.run_length = run_length_q;

	`LHQ_ASSERT_SAME(a_steady_led_lit, result_out.valid && result_out.led_mode == MODE_STEADY,
		result_out.led_on, "Steady mode result with LED off.")
	`LHQ_ASSERT_SAME(a_steady_phase_zero, mode_q == MODE_STEADY, phase_q == '0,
		"Phase counter runs in steady mode.")
	`LHQ_ASSERT_SAME(a_streak_nonempty, zone_q != ZONE_GOOD, count_q != '0,
		"Non-good streak with zero count.")
	`LHQ_ASSERT_NEXT(a_capture, item_in.valid && item_in.ready, valid_s1,
		"Accepted item lost from input register.")
endmodule
